// ----- design/skse_pkg.sv -----
package skse_pkg;

    localparam int KEY_W    = 32;
    localparam int CAPACITY = 16;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int SUM_W    = 36;
    localparam int KIND_W   = 3;
    localparam int STAT_W   = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
        logic [CNT_W-1:0]        index;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [CNT_W-1:0]        position;
        logic signed [KEY_W-1:0] key_out;
        logic [CNT_W-1:0]        count;
        logic signed [KEY_W-1:0] smallest;
        logic signed [KEY_W-1:0] largest;
        logic signed [SUM_W-1:0] key_sum;
    } t_out;

    typedef struct packed {
        logic load;
        logic compare;
        logic update;
        logic read_nth;
        logic read_last;
    } t_dp_cmd;

endpackage

// ----- design/skse_ctrl.sv -----
module skse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_strobe,
    output skse_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_RDN  = 3'd3;
    localparam logic [2:0] ST_RDL  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_strobe;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_RDN;
            ST_RDN:  n_state = ST_RDL;
            ST_RDL:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_RDL);
        end
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_strobe        = r_strobe;
    assign o_cmd.load      = start && (r_state == ST_IDLE);
    assign o_cmd.compare   = (r_state == ST_CMP);
    assign o_cmd.update    = (r_state == ST_UPD);
    assign o_cmd.read_nth  = (r_state == ST_RDN);
    assign o_cmd.read_last = (r_state == ST_RDL);

endmodule

// ----- design/skse_dp.sv -----
module skse_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  skse_pkg::t_dp_cmd i_cmd,
    input  skse_pkg::t_in     i_item,
    output skse_pkg::t_out    o_result
);

    localparam int CAP    = skse_pkg::CAPACITY;
    localparam int KEY_W  = skse_pkg::KEY_W;
    localparam int CNT_W  = skse_pkg::CNT_W;
    localparam int SUM_W  = skse_pkg::SUM_W;
    localparam int SLOT_W = skse_pkg::SLOT_W;

    skse_pkg::t_in                  r_cmd;
    logic [KEY_W-1:0]               r_cell [CAP];
    logic [KEY_W-1:0]               n_cell [CAP];
    logic [CAP-1:0]                 r_vld;
    logic [CAP-1:0]                 n_vld;
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               n_count;
    logic signed [SUM_W-1:0]        r_sum;
    logic signed [SUM_W-1:0]        n_sum;
    logic [CAP-1:0]                 r_less;
    logic [CAP-1:0]                 r_eq;
    logic [skse_pkg::STAT_W-1:0]    r_status;
    logic [skse_pkg::STAT_W-1:0]    n_status;
    logic [CNT_W-1:0]               r_pos;
    logic [CNT_W-1:0]               n_pos;
    logic [KEY_W-1:0]               r_key_out;
    logic [KEY_W-1:0]               r_largest;

    logic [CAP-1:0]                 less;
    logic [CAP-1:0]                 eq;
    logic [CAP-1:0]                 slot_hot;
    logic [CNT_W-1:0]               slot_pos;
    logic                           hit;
    logic                           full;
    logic                           read_ok;
    logic [CNT_W-1:0]               idx_m1;
    logic [CNT_W-1:0]               cnt_m1;
    logic [SLOT_W-1:0]              rd_addr;
    logic [KEY_W-1:0]               rd_data;
    logic signed [SUM_W-1:0]        key_ext;

    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            less[i] = r_vld[i] && ($signed(r_cell[i]) < r_cmd.key);
            eq[i]   = r_vld[i] && (r_cell[i] == r_cmd.key);
        end
    end

    always_comb begin
        slot_pos = '0;
        for (int i = 0; i < CAP; i++) begin
            if (i == 0) begin
                slot_hot[i] = ~r_less[i];
            end else begin
                slot_hot[i] = r_less[i-1] & ~r_less[i];
            end
            if (slot_hot[i]) begin
                slot_pos = slot_pos | CNT_W'(i + 1);
            end
        end
    end

    assign hit     = |(slot_hot & r_eq);
    assign full    = (r_count == CNT_W'(CAP));
    assign read_ok = (r_cmd.index != '0) && (r_cmd.index <= r_count);
    assign idx_m1  = r_cmd.index - CNT_W'(1);
    assign cnt_m1  = r_count - CNT_W'(1);
    assign rd_addr = i_cmd.read_nth ? idx_m1[SLOT_W-1:0] : cnt_m1[SLOT_W-1:0];
    assign rd_data = r_cell[rd_addr];
    assign key_ext = {{(SUM_W-KEY_W){r_cmd.key[KEY_W-1]}}, r_cmd.key};

    always_comb begin
        n_cell   = r_cell;
        n_vld    = r_vld;
        n_count  = r_count;
        n_sum    = r_sum;
        n_status = skse_pkg::STAT_MISS;
        n_pos    = '0;
        case (r_cmd.kind)
            skse_pkg::KIND_INSERT: begin
                if (hit) begin
                    n_pos = slot_pos;
                end else if (full) begin
                    n_status = skse_pkg::STAT_FULL;
                end else begin
                    for (int i = 0; i < CAP; i++) begin
                        if (slot_hot[i]) begin
                            n_cell[i] = r_cmd.key;
                        end else if (!r_less[i] && i > 0) begin
                            n_cell[i] = r_cell[i-1];
                        end
                    end
                    n_vld    = {r_vld[CAP-2:0], 1'b1};
                    n_count  = r_count + CNT_W'(1);
                    n_sum    = r_sum + key_ext;
                    n_status = skse_pkg::STAT_DONE;
                    n_pos    = slot_pos;
                end
            end
            skse_pkg::KIND_REMOVE: begin
                if (hit) begin
                    for (int i = 0; i < CAP - 1; i++) begin
                        if (!r_less[i]) begin
                            n_cell[i] = r_cell[i+1];
                        end
                    end
                    n_vld    = {1'b0, r_vld[CAP-1:1]};
                    n_count  = r_count - CNT_W'(1);
                    n_sum    = r_sum - key_ext;
                    n_status = skse_pkg::STAT_DONE;
                    n_pos    = slot_pos;
                end
            end
            skse_pkg::KIND_FIND: begin
                if (hit) begin
                    n_status = skse_pkg::STAT_DONE;
                    n_pos    = slot_pos;
                end
            end
            skse_pkg::KIND_READ: begin
                if (read_ok) begin
                    n_status = skse_pkg::STAT_DONE;
                    n_pos    = r_cmd.index;
                end
            end
            skse_pkg::KIND_CLEAR: begin
                if (r_count != '0) begin
                    n_vld    = '0;
                    n_count  = '0;
                    n_sum    = '0;
                    n_status = skse_pkg::STAT_DONE;
                end
            end
            default: begin
                n_status = skse_pkg::STAT_MISS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.update) begin
            r_vld   <= n_vld;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_item;
        end
        if (i_cmd.compare) begin
            r_less <= less;
            r_eq   <= eq;
        end
        if (i_cmd.update) begin
            r_cell   <= n_cell;
            r_status <= n_status;
            r_pos    <= n_pos;
        end
        if (i_cmd.read_nth) begin
            r_key_out <= (r_cmd.kind == skse_pkg::KIND_READ && read_ok) ? rd_data : '0;
        end
        if (i_cmd.read_last) begin
            r_largest <= rd_data;
        end
    end

    assign o_result.status   = r_status;
    assign o_result.position = r_pos;
    assign o_result.key_out  = r_key_out;
    assign o_result.count    = r_count;
    assign o_result.smallest = (r_count == '0) ? '0 : r_cell[0];
    assign o_result.largest  = (r_count == '0) ? '0 : r_largest;
    assign o_result.key_sum  = (r_count == '0) ? '1 : r_sum;

endmodule

// ----- design/sorted_key_set_engine.sv -----
// Sorted key set engine: up to 16 distinct signed 32-bit keys held in
// ascending order in a chain of cells.
// Command channel: drive i_item (kind, key, index) with start high; the
// transfer happens at the rising edge where start is high and busy is low.
// busy stays high while the command is being worked on.
// Result channel: o_result is valid for exactly one cycle, marked by
// o_strobe, which is registered out of the last read state. The receiver
// cannot stall; the result must be taken in that cycle.
// The controller steps through compare (all cells against the key at
// once), update (shift the chain on insert or remove), and two reads
// through the single cell read port (the n-th key, then the last key);
// it takes no new command until it is back in idle.
// A new command may be given in the cycle the result is shown.
// Reset (i_rst_n low at a rising edge) empties the set, clears the sum and
// returns the controller to idle; cell contents are not cleared.
module sorted_key_set_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  skse_pkg::t_in  i_item,
    output logic           o_strobe,
    output skse_pkg::t_out o_result
);

    skse_pkg::t_dp_cmd dp_cmd;

    skse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (dp_cmd)
    );

    skse_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

    a_strobe_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 5))
        else $error("result without a command transfer five cycles earlier");

    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.count <= skse_pkg::CNT_W'(skse_pkg::CAPACITY)))
        else $error("count beyond capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == skse_pkg::STAT_FULL)
            |-> (o_result.count == skse_pkg::CNT_W'(skse_pkg::CAPACITY)))
        else $error("full status with room left");

endmodule

// ----- test/sorted_key_set_engine_test.sv -----
module sorted_key_set_engine_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KIND_W   = skse_pkg::KIND_W;
    localparam int KEY_W    = skse_pkg::KEY_W;
    localparam int CNT_W    = skse_pkg::CNT_W;
    localparam int SUM_W    = skse_pkg::SUM_W;
    localparam int CAPACITY = skse_pkg::CAPACITY;

    localparam logic [KIND_W-1:0]       KIND_LAST  = {KIND_W{1'b1}};
    localparam logic signed [KEY_W-1:0] KEY_MAX    = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_MIN    = {1'b1, {(KEY_W-1){1'b0}}};
    localparam int                      TARGET_OPS = 550;
    localparam int                      POOL_SIZE  = 20;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    skse_pkg::t_in  cmd_bus = '0;
    logic           busy;
    logic           o_strobe;
    skse_pkg::t_out o_result;

    skse_pkg::t_in  pending_cmds[$];
    skse_pkg::t_out expected_results[$];

    logic signed [KEY_W-1:0] set_keys[CAPACITY];
    int                      set_size = 0;
    logic signed [63:0]      set_sum  = '0;

    logic signed [KEY_W-1:0] key_pool[POOL_SIZE];
    int                      planned_ops = 0;
    int                      sent = 0;
    int                      mismatches = 0;
    bit                      took = 1'b0;

    sorted_key_set_engine u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (cmd_bus),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #6 i_clk = ~i_clk;

    function automatic skse_pkg::t_out predict_result(skse_pkg::t_in cmd);
        skse_pkg::t_out r;
        int             slot;
        bit             hit;
        r        = '0;
        r.status = skse_pkg::STAT_MISS;
        slot     = 0;
        while (slot < set_size && $signed(set_keys[slot]) < $signed(cmd.key))
            slot++;
        hit = (slot < set_size) && (set_keys[slot] == cmd.key);
        case (cmd.kind)
            skse_pkg::KIND_INSERT: begin
                if (hit) begin
                    r.position = CNT_W'(slot + 1);
                end else if (set_size >= CAPACITY) begin
                    r.status = skse_pkg::STAT_FULL;
                end else begin
                    for (int i = set_size; i > slot; i--)
                        set_keys[i] = set_keys[i-1];
                    set_keys[slot] = cmd.key;
                    set_size++;
                    set_sum    = set_sum + 64'($signed(cmd.key));
                    r.status   = skse_pkg::STAT_DONE;
                    r.position = CNT_W'(slot + 1);
                end
            end
            skse_pkg::KIND_REMOVE: begin
                if (hit) begin
                    set_sum = set_sum - 64'($signed(cmd.key));
                    for (int i = slot; i + 1 < set_size; i++)
                        set_keys[i] = set_keys[i+1];
                    set_size--;
                    r.status   = skse_pkg::STAT_DONE;
                    r.position = CNT_W'(slot + 1);
                end
            end
            skse_pkg::KIND_FIND: begin
                if (hit) begin
                    r.status   = skse_pkg::STAT_DONE;
                    r.position = CNT_W'(slot + 1);
                end
            end
            skse_pkg::KIND_READ: begin
                if (cmd.index >= 1 && cmd.index <= set_size) begin
                    r.status   = skse_pkg::STAT_DONE;
                    r.position = cmd.index;
                    r.key_out  = set_keys[cmd.index-1];
                end
            end
            skse_pkg::KIND_CLEAR: begin
                if (set_size != 0) begin
                    set_size = 0;
                    set_sum  = '0;
                    r.status = skse_pkg::STAT_DONE;
                end
            end
            default: ;
        endcase
        r.count = CNT_W'(set_size);
        if (set_size == 0) begin
            r.key_sum = '1;
        end else begin
            r.smallest = set_keys[0];
            r.largest  = set_keys[set_size-1];
            r.key_sum  = set_sum[SUM_W-1:0];
        end
        return r;
    endfunction

    task automatic report(string field, longint want_v, longint got_v);
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
        mismatches++;
    endtask

    // Transfer on the rising edge; check results against the oldest prediction.
    always @(posedge i_clk) begin
        skse_pkg::t_out want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none actual %h", $time, o_result);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status)
                    report("status", want.status, o_result.status);
                if (o_result.position !== want.position)
                    report("position", want.position, o_result.position);
                if (o_result.key_out !== want.key_out)
                    report("key_out", want.key_out, o_result.key_out);
                if (o_result.count !== want.count)
                    report("count", want.count, o_result.count);
                if (o_result.smallest !== want.smallest)
                    report("smallest", want.smallest, o_result.smallest);
                if (o_result.largest !== want.largest)
                    report("largest", want.largest, o_result.largest);
                if (o_result.key_sum !== want.key_sum)
                    report("key_sum", want.key_sum, o_result.key_sum);
            end
        end
        took = i_rst_n && start && !busy;
        if (took)
            expected_results.push_back(predict_result(cmd_bus));
    end

    // Hold the command until transferred; idle at random outside the burst window.
    always @(negedge i_clk) begin
        bit gap;
        gap = !(sent >= 200 && sent < 330) && ($urandom_range(0, 99) < 23);
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (pending_cmds.size() != 0 && !gap) begin
                start   <= 1'b1;
                cmd_bus <= pending_cmds.pop_front();
                sent++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic add_cmd(logic [KIND_W-1:0] kind, logic signed [KEY_W-1:0] key,
                           logic [CNT_W-1:0] index);
        skse_pkg::t_in c;
        c.kind  = kind;
        c.key   = key;
        c.index = index;
        pending_cmds.push_back(c);
        if (kind <= skse_pkg::KIND_CLEAR)
            planned_ops++;
    endtask

    task automatic refill_pool();
        int mode;
        mode = $urandom_range(0, 4);
        for (int i = 0; i < POOL_SIZE; i++) begin
            case (mode)
                0: key_pool[i] = KEY_MAX - KEY_W'($urandom_range(0, 40));
                1: key_pool[i] = KEY_MIN + KEY_W'($urandom_range(0, 40));
                2: key_pool[i] = KEY_W'($signed($urandom_range(0, 40)) - 20);
                default: key_pool[i] = $urandom;
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            key_pool[0] = KEY_MAX;
        if ($urandom_range(0, 3) == 0)
            key_pool[1] = KEY_MIN;
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, POOL_SIZE-1)];
    endfunction

    task automatic add_churn(int n);
        int w;
        for (int i = 0; i < n; i++) begin
            w = $urandom_range(0, 99);
            if (w < 35)
                add_cmd(skse_pkg::KIND_INSERT, pick_key(), CNT_W'($urandom));
            else if (w < 60)
                add_cmd(skse_pkg::KIND_REMOVE, pick_key(), CNT_W'($urandom));
            else if (w < 75)
                add_cmd(skse_pkg::KIND_FIND, pick_key(), CNT_W'($urandom));
            else if (w < 96)
                add_cmd(skse_pkg::KIND_READ, $urandom,
                        CNT_W'($urandom_range(0, CAPACITY + 1)));
            else
                add_cmd(skse_pkg::KIND_CLEAR, $urandom, CNT_W'($urandom));
        end
    endtask

    initial begin
        int round;
        add_cmd(skse_pkg::KIND_CLEAR, '0, '0);
        add_cmd(skse_pkg::KIND_FIND, '0, '0);
        add_cmd(skse_pkg::KIND_REMOVE, KEY_MAX, '0);
        add_cmd(skse_pkg::KIND_READ, '0, '0);
        add_cmd(skse_pkg::KIND_INSERT, KEY_MAX, '0);
        add_cmd(skse_pkg::KIND_INSERT, KEY_MIN, '0);
        add_cmd(skse_pkg::KIND_INSERT, '0, '0);
        add_cmd(skse_pkg::KIND_INSERT, '0, '1);
        add_cmd(skse_pkg::KIND_FIND, KEY_MAX, '0);
        add_cmd(skse_pkg::KIND_FIND, KEY_W'(-1), '0);
        add_cmd(skse_pkg::KIND_READ, '0, CNT_W'(1));
        add_cmd(skse_pkg::KIND_READ, '0, CNT_W'(3));
        add_cmd(skse_pkg::KIND_READ, '0, CNT_W'(4));
        add_cmd(skse_pkg::KIND_READ, '1, '1);
        add_cmd(skse_pkg::KIND_REMOVE, KEY_MIN, '0);
        add_cmd(skse_pkg::KIND_REMOVE, KEY_MIN, '0);
        add_cmd(skse_pkg::KIND_CLEAR + 3'd1, KEY_MAX, '1);
        add_cmd(KIND_LAST - 3'd1, '0, '0);
        add_cmd(KIND_LAST, '1, '1);
        add_cmd(skse_pkg::KIND_CLEAR, '0, '0);

        while (planned_ops < TARGET_OPS) begin
            round = $urandom_range(0, 9);
            refill_pool();
            if (round < 4) begin
                for (int i = 0; i < POOL_SIZE + $urandom_range(0, 3); i++)
                    add_cmd(skse_pkg::KIND_INSERT, key_pool[i % POOL_SIZE], CNT_W'($urandom));
                add_churn($urandom_range(10, 25));
            end else if (round < 8) begin
                add_churn($urandom_range(15, 40));
            end else begin
                for (int i = 0; i < $urandom_range(4, 10); i++)
                    add_cmd(KIND_W'($urandom), $urandom, CNT_W'($urandom));
            end
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
        repeat (12) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
